/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sha256_pkg.sv */
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // compressor start request with block buffer read address, and compressor status
  typedef struct packed {
    logic       start;
    logic [5:0] rd_addr;
  } cmp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

/* rtl/core/sha256_blkbuf.sv */
// 16 x 32-bit block buffer, byte-write, registered read
module sha256_blkbuf (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [5:0]           wr_addr,
  input  logic [7:0]           wr_byte,
  input  logic [3:0]           rd_addr,
  output sha256_pkg::word_t    rd_data
);
  import sha256_pkg::*;

  logic [3:0][7:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][2'd3 - wr_addr[1:0]] <= wr_byte;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/sha256_core.sv */
// Compression engine: 16-entry schedule window in a shift register, one round per cycle
module sha256_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    init,
  output logic [3:0]              buf_addr,
  input  sha256_pkg::word_t       buf_data,
  output sha256_pkg::cmp_stat_t   stat,
  input  logic [2:0]              hrd_addr,
  output sha256_pkg::word_t       hrd_data
);
  import sha256_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_ROUND = 2'd2;
  localparam logic [1:0] S_FOLD  = 2'd3;

  logic [1:0] state;
  logic [6:0] cnt;
  word_t      h [8];
  word_t      v [8];
  word_t      w [16];  // schedule window, shift line
  logic       done;
  word_t      w_new;
  word_t      t1, t2;

  // round index = cnt; the first buffer word arrives in the cycle after its address
  assign buf_addr = cnt[3:0];
  assign stat     = '{busy: (state != S_IDLE), done: done};
  assign hrd_data = h[hrd_addr];

  assign w_new = sig1(w[14]) + w[9] + sig0(w[1]) + w[0];
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[cnt[5:0]] + w[0];
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_HASH[i];
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (init) begin
            for (int i = 0; i < 8; i++) h[i] <= INIT_HASH[i];
          end
          if (start) begin
            state <= S_LOAD;
            cnt   <= 7'd1;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= buf_data;
          if (cnt == 7'd16) begin
            state <= S_ROUND;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          if (cnt == 7'd63) state <= S_FOLD;
          cnt <= cnt + 7'd1;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_fold_done, state == S_FOLD, done && state == S_IDLE, "fold must finish")
  `ASSERT_CLK(a_cnt_load, !(state == S_LOAD && cnt > 7'd16), "load count overrun")
  `ASSERT_CLK(a_idle_init, !(init && start && state != S_IDLE), "start while busy")

endmodule

/* rtl/core/sha256_stream_hasher_unit.sv */
// Channel | Dir | Signals
// in      | in  | in_valid/in_ready, data_byte, byte_valid, end_of_message
// out     | out | out_valid/out_ready, digest_word, word_index, last_word
// Byte items are taken while in_ready is high; the 64th byte of a block
// starts the compressor, which holds input through 16 buffer reads, 64 rounds
// and the fold. An end item pads byte by byte, with one or two compressions,
// then emits eight words; the next item is taken after word 7 is taken.
// rst is synchronous and returns the hash to the initial values.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;  // compress after a full block
  localparam logic [2:0] S_PAD  = 3'd2;  // writing 0x80 / zeros / length
  localparam logic [2:0] S_PCMP = 3'd3;  // compress during padding
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic        pad_first;   // next pad byte is 0x80
  logic        len_phase;   // writing length bytes
  logic [2:0]  oidx;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        start;
  logic        init;
  logic [3:0]  buf_addr;
  word_t       buf_data;
  cmp_stat_t   stat;
  word_t       hword;

  sha256_blkbuf u_buf (
    .clk(clk), .wr_en(wr_en), .wr_addr(fill), .wr_byte(wr_byte),
    .rd_addr(buf_addr), .rd_data(buf_data)
  );

  sha256_core u_core (
    .clk(clk), .rst(rst), .start(start), .init(init), .buf_addr(buf_addr),
    .buf_data(buf_data), .stat(stat), .hrd_addr(oidx), .hrd_data(hword)
  );

  assign in_ready    = (state == S_IN);
  assign out_valid   = (state == S_OUT);
  assign digest_word = hword;
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);
  assign init        = (state == S_OUT) && out_ready && (oidx == 3'd7);

  logic [2:0] lsel;
  assign lsel = 3'd7 - fill[2:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = data_byte;
    start   = 1'b0;
    if (state == S_IN && in_valid && byte_valid) begin
      wr_en = 1'b1;
      start = (fill == 6'd63);
    end else if (state == S_PAD) begin
      wr_en = 1'b1;
      if (pad_first) wr_byte = PAD_BYTE;
      else if (len_phase) wr_byte = bits[{lsel, 3'b000} +: 8];
      else wr_byte = 8'h00;
      start = (fill == 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      fill      <= '0;
      bits      <= '0;
      pad_first <= 1'b0;
      len_phase <= 1'b0;
      oidx      <= '0;
    end else begin
      case (state)
        S_IN: begin
          if (in_valid) begin
            if (byte_valid) begin
              fill <= fill + 6'd1;
              bits <= bits + 64'd8;
            end
            if (end_of_message) begin
              state     <= (byte_valid && fill == 6'd63) ? S_PCMP : S_PAD;
              pad_first <= 1'b1;
            end else if (byte_valid && fill == 6'd63) begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (stat.done) state <= S_IN;
        end
        S_PAD: begin
          fill      <= fill + 6'd1;
          pad_first <= 1'b0;
          if (fill == LEN_POS - 6'd1 && !len_phase) len_phase <= 1'b1;
          if (fill == 6'd63) state <= S_PCMP;
        end
        S_PCMP: begin
          if (stat.done) begin
            state <= len_phase ? S_OUT : S_PAD;
            oidx  <= '0;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state     <= S_IN;
              bits      <= '0;
              len_phase <= 1'b0;
              fill      <= '0;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_in_idle, !(in_ready && stat.busy), "input taken while compressing")
  `ASSERT_CLK(a_out_idle, !(out_valid && stat.busy), "digest read while compressing")
  `ASSERT_NEXT(a_last, out_valid && out_ready && last_word, in_ready, "no return after digest")

endmodule
